>>> src/avss_pkg.sv
// Shared types and constants for the animated value slew smoother.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package avss_pkg;

  // Field widths
  localparam int VAL_W = 32;  // signed Q16.16 values
  localparam int DT_W  = 24;  // unsigned Q8.16 time
  localparam int CH_W  = 6;   // channel field
  localparam int K_W   = 40;  // move factor (eff * dt) >> 16
  localparam int MV_W  = 34;  // capped smooth move

  localparam int CHANNELS_DEF = 64;

  // 0.11 in Q16.16, rounded
  localparam logic [VAL_W-1:0] SNAP_Q16 = 32'd7209;

  // Smooth move cap; anything this large saturates the result anyway
  localparam logic [63:0] MV_CAP = 64'h0000_0002_0000_0000;

  // Animation modes
  localparam logic FUNC_LINEAR = 1'b0;
  localparam logic FUNC_SMOOTH = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture accepted item, read table
    logic mul_k;   // k = eff * dt
    logic mul_lo;  // mag * k[23:0]
    logic mul_hi;  // mag * k[39:24]
    logic acc;     // combine partial products, cap the move
    logic fin;     // write back, load result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic func;
  } sts_t;

endpackage

`default_nettype wire

>>> src/avss_ctrl.sv
// Controller state machine for the slew smoother.
// Depends on avss_pkg; drives commands into avss_dp.
`default_nettype none

module avss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire avss_pkg::sts_t sts,
  output avss_pkg::cmd_t     cmd
);
  import avss_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_K    = 3'd1;
  localparam logic [2:0] S_LO   = 3'd2;
  localparam logic [2:0] S_HI   = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_K;
        end
      end
      S_K: begin
        cmd.mul_k = 1'b1;
        state_nxt = (sts.func == FUNC_SMOOTH) ? S_LO : S_FIN;
      end
      S_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_HI;
      end
      S_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the result register can take the item
        if (out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/avss_dp.sv
// Datapath: value table, shared 32x24 multiplier, move and saturation logic.
// Depends on avss_pkg; sequenced by avss_ctrl.
`default_nettype none

module avss_dp #(
  parameter int CHANNELS = avss_pkg::CHANNELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire avss_pkg::cmd_t                    cmd,
  output avss_pkg::sts_t                         sts,
  input  wire logic                              cfg_wr_en,
  input  wire logic signed [avss_pkg::VAL_W-1:0] cfg_wr_data,
  input  wire logic                              in_func,
  input  wire logic        [avss_pkg::CH_W-1:0]  in_channel,
  input  wire logic signed [avss_pkg::VAL_W-1:0] in_goal,
  input  wire logic signed [avss_pkg::VAL_W-1:0] in_speed,
  input  wire logic        [avss_pkg::DT_W-1:0]  in_delta_time,
  output logic signed      [avss_pkg::VAL_W-1:0] out_new_value
);
  import avss_pkg::*;

  // Only 2^CH_W channels can ever be addressed
  localparam int DEPTH = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [VAL_W-1:0] spd_ofs_r;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]        vld_r;
  logic signed [VAL_W-1:0] rd_r;
  logic                    rd_vld_r;

  logic [IDX_W-1:0]        idx_r;
  logic                    func_r;
  logic signed [VAL_W-1:0] goal_r;
  logic [VAL_W-1:0]        eff_r;
  logic [DT_W-1:0]         dt_r;
  logic [K_W-1:0]          k_r;
  logic [VAL_W-1:0]        mag_r;
  logic                    neg_r;
  logic [VAL_W+DT_W-1:0]   p_lo_r;
  logic [VAL_W+16-1:0]     p_hi_r;
  logic [MV_W-1:0]         mv_r;
  logic signed [VAL_W-1:0] out_r;

  logic [CH_W-1:0]         rem;
  logic [IDX_W-1:0]        idx;
  logic signed [VAL_W:0]   eff_sum;
  logic [VAL_W-1:0]        eff_nxt;
  logic signed [VAL_W-1:0] cur;
  logic signed [VAL_W:0]   diff;
  logic signed [VAL_W:0]   diff_abs;
  logic [VAL_W-1:0]        mul_a;
  logic [DT_W-1:0]         mul_b;
  logic [VAL_W+DT_W-1:0]   mul_p;
  logic [71:0]             sum;
  logic [55:0]             q;
  logic signed [35:0]      sm;
  logic signed [VAL_W-1:0] res;

  // channel modulo CHANNELS by conditional subtraction
  always_comb begin
    rem = in_channel;
    for (int j = CH_W - 1; j >= 0; j--) begin
      if ((CHANNELS << j) < (1 << CH_W)) begin
        if (rem >= CH_W'(CHANNELS << j)) begin
          rem = rem - CH_W'(CHANNELS << j);
        end
      end
    end
  end
  assign idx = rem[IDX_W-1:0];

  // effective speed, clamped at zero
  assign eff_sum = (VAL_W+1)'(in_speed) + (VAL_W+1)'(spd_ofs_r);
  assign eff_nxt = eff_sum[VAL_W] ? '0 : eff_sum[VAL_W-1:0];

  // never-written entries read as zero
  assign cur      = rd_vld_r ? rd_r : '0;
  assign diff     = (VAL_W+1)'(goal_r) - (VAL_W+1)'(cur);
  assign diff_abs = diff[VAL_W] ? -diff : diff;

  // shared multiplier
  always_comb begin
    priority if (cmd.mul_k) begin
      mul_a = eff_r;
      mul_b = dt_r;
    end else if (cmd.mul_hi) begin
      mul_a = mag_r;
      mul_b = {{(DT_W-(K_W-DT_W)){1'b0}}, k_r[K_W-1:DT_W]};
    end else begin
      mul_a = mag_r;
      mul_b = k_r[DT_W-1:0];
    end
  end
  assign mul_p = (VAL_W+DT_W)'(mul_a) * (VAL_W+DT_W)'(mul_b);

  // combine partial products, drop 16 fraction bits
  assign sum = {16'b0, p_lo_r} + {p_hi_r, 24'b0};
  assign q   = sum[71:16];

  // result select
  always_comb begin
    sm = neg_r ? (36'(cur) - $signed({2'b00, mv_r}))
               : (36'(cur) + $signed({2'b00, mv_r}));
    if (func_r == FUNC_LINEAR) begin
      if ({{(K_W-VAL_W){1'b0}}, mag_r} <= k_r) begin
        res = goal_r;  // would reach or pass the goal: snap
      end else if (neg_r) begin
        res = cur - $signed(k_r[VAL_W-1:0]);
      end else begin
        res = cur + $signed(k_r[VAL_W-1:0]);
      end
    end else begin
      if (mag_r <= SNAP_Q16) begin
        res = goal_r;
      end else if (sm[35:31] != {5{sm[35]}}) begin
        res = sm[35] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
        res = sm[VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_ofs_r <= '0;
      vld_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        spd_ofs_r <= cfg_wr_data;
      end
      if (cmd.fin) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_r     <= mem[idx];
      rd_vld_r <= vld_r[idx];
      idx_r    <= idx;
      func_r   <= in_func;
      goal_r   <= in_goal;
      eff_r    <= eff_nxt;
      dt_r     <= in_delta_time;
    end
    if (cmd.mul_k) begin
      k_r   <= mul_p[VAL_W+DT_W-1:16];
      mag_r <= diff_abs[VAL_W-1:0];
      neg_r <= diff[VAL_W];
    end
    if (cmd.mul_lo) begin
      p_lo_r <= mul_p;
    end
    if (cmd.mul_hi) begin
      p_hi_r <= mul_p[VAL_W+16-1:0];
    end
    if (cmd.acc) begin
      mv_r <= (q > 56'(MV_CAP)) ? MV_W'(MV_CAP) : q[MV_W-1:0];
    end
    if (cmd.fin) begin
      mem[idx_r] <= res;
      out_r      <= res;
    end
  end

  assign sts.func      = func_r;
  assign out_new_value = out_r;

endmodule

`default_nettype wire

>>> src/animated_value_slew_smoother.sv
// Top level of the animated value slew smoother.
// Depends on avss_pkg, avss_ctrl and avss_dp.
//
// Usage:
//   Input channel (in_valid/in_ready): one item names a channel, a goal, a
//   speed, an elapsed time and a mode (in_func: linear ramp or smooth approach).
//   The block reads that channel's value, moves it toward the goal, writes it
//   back and returns the new value as one item on the result channel
//   (out_valid/out_ready).
//   Configuration: cfg_wr_en with cfg_wr_data writes the speed offset;
//   write it only while the block is idle.
//   Steps: a linear item goes through load, move factor and write-back; a
//   smooth item also forms the low and high partial products and combines
//   them before write-back. The next item is taken in the cycle after the
//   result register loads. The steps follow from the single shared 32x24
//   multiplier: once for the move factor, twice more (low and high halves)
//   for the smooth move product, then a step to combine the partial products.
//   One item is in work at a time; a finished result waits in the output
//   register while the next item is accepted and processed.
//   Receiver stall: a finished item is held in the final step until the output
//   register frees up; nothing is dropped.
//   Reset (rst_n low, synchronous): all channel values read as zero, the speed
//   offset returns to zero, no result is pending and the block is ready at once.
`default_nettype none

module animated_value_slew_smoother #(
  parameter int CHANNELS = avss_pkg::CHANNELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic signed [avss_pkg::VAL_W-1:0] cfg_wr_data,
  // input items
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_func,
  input  wire logic        [avss_pkg::CH_W-1:0]  in_channel,
  input  wire logic signed [avss_pkg::VAL_W-1:0] in_goal,
  input  wire logic signed [avss_pkg::VAL_W-1:0] in_speed,
  input  wire logic        [avss_pkg::DT_W-1:0]  in_delta_time,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed      [avss_pkg::VAL_W-1:0] out_new_value
);
  import avss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence each item through load, multiply steps and write-back
  avss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, multiplier and result register
  avss_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_func       (in_func),
    .in_channel    (in_channel),
    .in_goal       (in_goal),
    .in_speed      (in_speed),
    .in_delta_time (in_delta_time),
    .out_new_value (out_new_value)
  );

endmodule

`default_nettype wire

>>> src/avss_chk.sv
// Port-level checker for the slew smoother, bound to the top level.
// Depends on avss_pkg for field widths.
`default_nettype none

module avss_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [avss_pkg::VAL_W-1:0] out_new_value
);
  import avss_pkg::*;

  // stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_value))
    else $error("result changed or dropped while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while busy");

  // a new result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in work");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty and ready after reset");

endmodule

bind animated_value_slew_smoother avss_chk u_avss_chk (.*);

`default_nettype wire
